FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SKAM_CHECK(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SKAM_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/skam_pkg.sv
// types and constants of the sorted key adjacency matrix
`timescale 1ns / 1ps

package skam_pkg;

	localparam int KEY_W = 32;
	localparam int NB_W = 16;
	localparam int ST_W = 2;
	localparam int FN_W = 2;
	localparam int VC_W = 5;
	localparam int RESULT_LIMIT = 16;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [VC_W-1:0] VC_RESET = 5'd16;
	localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [FN_W-1:0] {
		FN_INSERT = 2'd0,
		FN_EDGE   = 2'd1,
		FN_DUMP   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic ins;
		logic clr;
		logic loaded;
		logic at_end;
		logic set_row;
	} cell_cmd_t;

	typedef struct packed {
		logic lt;
		logic hit_src;
		logic hit_dst;
	} cell_stat_t;

endpackage

FILE: rtl/skam_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface skam_req_if;
	logic                       valid;
	logic                       ready;
	logic [skam_pkg::FN_W-1:0]  func;
	logic signed [skam_pkg::KEY_W-1:0] key;
	logic signed [skam_pkg::KEY_W-1:0] other_key;

	modport source (output valid, func, key, other_key, input ready);
	modport sink (input valid, func, key, other_key, output ready);
endinterface

interface skam_rsp_if;
	logic                       valid;
	logic                       ready;
	logic signed [skam_pkg::KEY_W-1:0] row_key;
	logic [skam_pkg::NB_W-1:0]  neighbors;
	logic [skam_pkg::ST_W-1:0]  status;
	logic                       is_last;

	modport source (output valid, row_key, neighbors, status, is_last, input ready);
	modport sink (input valid, row_key, neighbors, status, is_last, output ready);
endinterface

FILE: rtl/skam_cell.sv
// one vertex cell: key, adjacency row and compares against the request keys
`timescale 1ns / 1ps

module skam_cell #(
	parameter int NV = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skam_pkg::cell_cmd_t   cmd,
	input  skam_pkg::key_t        new_key,
	input  skam_pkg::key_t        other_key,
	input  skam_pkg::key_t        prev_key,
	input  logic                  prev_lt,
	input  logic [NV-1:0]         col_mask,
	output skam_pkg::key_t        key_q,
	output logic [NV-1:0]         row_q,
	output skam_pkg::cell_stat_t  stat
);

	assign stat.lt      = cmd.loaded && (new_key < key_q);
	assign stat.hit_src = cmd.loaded && (key_q == new_key);
	assign stat.hit_dst = cmd.loaded && (key_q == other_key);

	// shift right from the neighbor or take the new key
	always_ff @(posedge clk) begin
		if (cmd.ins && (stat.lt || cmd.at_end)) begin
			key_q <= prev_lt ? prev_key : new_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.clr) begin
			row_q <= '0;
		end else if (cmd.set_row) begin
			row_q <= row_q | col_mask;
		end
	end

endmodule

FILE: rtl/skam_cfg.sv
// apb register block holding vertex_count
`timescale 1ns / 1ps

module skam_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skam_pkg::APB_AW-1:0] paddr,
	input  logic [skam_pkg::APB_DW-1:0] pwdata,
	output logic [skam_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [skam_pkg::VC_W-1:0]   vertex_count
);

	logic                      sel_vc;
	logic [skam_pkg::VC_W-1:0] vc_q;

	assign pready = 1'b1;
	assign sel_vc = (paddr[skam_pkg::APB_AW-1:2] == skam_pkg::REG_VERTEX_COUNT);
	assign prdata = sel_vc ? skam_pkg::APB_DW'(vc_q) : '0;
	assign vertex_count = vc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= skam_pkg::VC_RESET;
		end else if (psel && penable && pwrite && pready && sel_vc) begin
			vc_q <= pwdata[skam_pkg::VC_W-1:0];
		end
	end

endmodule

FILE: rtl/sorted_key_adjacency_matrix.sv
// sorted key adjacency matrix: top level
// Channels: req carries one request (func, key, other_key), rsp carries
// results (row_key, neighbors, status, is_last); both move on valid and ready.
// Configuration: apb port, register vertex_count at byte address 0.
// A request lands in a holding register and executes from there in a
// row of MAX_VERTICES cells, each holding one sorted key and its row.
// Insert, add edge and clear execute in all cells at once: all cells compare
// the key, and an insert shifts one place to the right to open the sorted slot.
// Their single result is registered in the output register; a new request
// is taken only after the last has left the holding register. A dump enters
// S_DUMP, then, unless rsp stalls, gives one row per cycle by cell index.
// While rsp is stalled the output register holds, the dump counter pauses,
// and one more request may wait in the holding register.
// Reset empties the store, clears all rows and sets vertex_count to 16.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_key_adjacency_matrix #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	skam_req_if.sink                    req,
	skam_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skam_pkg::APB_AW-1:0] paddr,
	input  logic [skam_pkg::APB_DW-1:0] pwdata,
	output logic [skam_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int NV = MAX_VERTICES;
	localparam int CW = $clog2(NV + 1);
	localparam int IW = $clog2(NV);
	localparam int CMPW = (CW > skam_pkg::VC_W) ? CW : skam_pkg::VC_W;

	logic [skam_pkg::VC_W-1:0] vertex_count;

	// holding register
	logic                  hold_q;
	skam_pkg::func_t       h_func_q;
	skam_pkg::key_t        h_key_q;
	skam_pkg::key_t        h_other_q;

	// store control
	logic [CW-1:0]         cnt_q;
	logic                  edges_q;
	logic [IW-1:0]         didx_q, didx_d;
	skam_pkg::state_t      state_q, state_d;

	// output register
	logic                  ov_q;
	skam_pkg::key_t        o_key_q, o_key_d;
	logic [skam_pkg::NB_W-1:0] o_nb_q, o_nb_d;
	skam_pkg::status_t     o_st_q, o_st_d;
	logic                  o_last_q, o_last_d;

	logic                  slot_free, take, out_load, ins_en, clr_en, edge_en;
	logic                  full, dump_last;
	logic [CMPW-1:0]       cap, dump_n;

	skam_pkg::key_t        key_a [NV];
	logic [NV-1:0]         row_a [NV];
	skam_pkg::cell_stat_t  stat_a [NV];
	skam_pkg::cell_cmd_t   cmd_a [NV];
	logic [NV-1:0]         loaded, src_v, dst_v, src_first, dst_first;
	logic [NV-1:0]         sel_row;
	logic [skam_pkg::NB_W-1:0] sel_nb;

	skam_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_count (vertex_count)
	);

	genvar i;
	generate
		for (i = 0; i < NV; i++) begin : g_cell
			assign loaded[i] = (cnt_q > CW'(i));
			assign src_v[i] = stat_a[i].hit_src;
			assign dst_v[i] = stat_a[i].hit_dst;
			assign cmd_a[i].ins = ins_en;
			assign cmd_a[i].clr = clr_en;
			assign cmd_a[i].loaded = loaded[i];
			assign cmd_a[i].at_end = (cnt_q == CW'(i));
			assign cmd_a[i].set_row = edge_en && src_first[i];

			if (i == 0) begin : g_head
				skam_cell #(.NV(NV)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.cmd       (cmd_a[i]),
					.new_key   (h_key_q),
					.other_key (h_other_q),
					.prev_key  (h_key_q),
					.prev_lt   (1'b0),
					.col_mask  (dst_first),
					.key_q     (key_a[i]),
					.row_q     (row_a[i]),
					.stat      (stat_a[i])
				);
			end else begin : g_body
				skam_cell #(.NV(NV)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.cmd       (cmd_a[i]),
					.new_key   (h_key_q),
					.other_key (h_other_q),
					.prev_key  (key_a[i-1]),
					.prev_lt   (stat_a[i-1].lt),
					.col_mask  (dst_first),
					.key_q     (key_a[i]),
					.row_q     (row_a[i]),
					.stat      (stat_a[i])
				);
			end
		end

		if (NV >= skam_pkg::NB_W) begin : g_nb_cut
			assign sel_nb = sel_row[skam_pkg::NB_W-1:0];
		end else begin : g_nb_ext
			assign sel_nb = skam_pkg::NB_W'(sel_row);
		end
	endgenerate

	// first matching cell for each key
	assign src_first = src_v & (~src_v + NV'(1));
	assign dst_first = dst_v & (~dst_v + NV'(1));

	assign cap = (CMPW'(vertex_count) < CMPW'(NV)) ? CMPW'(vertex_count) : CMPW'(NV);
	assign full = (CMPW'(cnt_q) >= cap);
	assign dump_n = (CMPW'(cnt_q) > CMPW'(skam_pkg::RESULT_LIMIT)) ?
		CMPW'(skam_pkg::RESULT_LIMIT) : CMPW'(cnt_q);
	assign dump_last = ((CMPW'(didx_q) + CMPW'(1)) == dump_n);
	assign sel_row = row_a[didx_q];

	assign slot_free = !ov_q || rsp.ready;
	assign req.ready = !hold_q;

	always_comb begin
		state_d = state_q;
		didx_d = didx_q;
		take = 1'b0;
		out_load = 1'b0;
		ins_en = 1'b0;
		clr_en = 1'b0;
		edge_en = 1'b0;
		o_key_d = '0;
		o_nb_d = '0;
		o_st_d = skam_pkg::ST_OK;
		o_last_d = 1'b1;
		case (state_q)
			skam_pkg::S_IDLE: begin
				if (hold_q && slot_free) begin
					take = 1'b1;
					case (h_func_q)
						skam_pkg::FN_INSERT: begin
							out_load = 1'b1;
							if (edges_q || full) begin
								o_st_d = skam_pkg::ST_FULL;
							end else begin
								ins_en = 1'b1;
							end
						end
						skam_pkg::FN_EDGE: begin
							out_load = 1'b1;
							if (cnt_q == '0) begin
								o_st_d = skam_pkg::ST_EMPTY;
							end else if (src_v == '0 || dst_v == '0) begin
								o_st_d = skam_pkg::ST_MISSING;
							end else begin
								edge_en = 1'b1;
							end
						end
						skam_pkg::FN_DUMP: begin
							if (cnt_q == '0) begin
								out_load = 1'b1;
								o_st_d = skam_pkg::ST_EMPTY;
							end else begin
								state_d = skam_pkg::S_DUMP;
								didx_d = '0;
							end
						end
						skam_pkg::FN_CLEAR: begin
							out_load = 1'b1;
							clr_en = 1'b1;
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			skam_pkg::S_DUMP: begin
				if (slot_free) begin
					out_load = 1'b1;
					o_key_d = key_a[didx_q];
					o_nb_d = sel_nb;
					o_last_d = dump_last;
					if (dump_last) begin
						state_d = skam_pkg::S_IDLE;
						didx_d = '0;
					end else begin
						didx_d = didx_q + IW'(1);
					end
				end
			end
			default: begin
				state_d = skam_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skam_pkg::S_IDLE;
			didx_q <= '0;
		end else begin
			state_q <= state_d;
			didx_q <= didx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q <= '0;
			edges_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				hold_q <= 1'b1;
			end else if (take) begin
				hold_q <= 1'b0;
			end
			if (clr_en) begin
				cnt_q <= '0;
				edges_q <= 1'b0;
			end else begin
				if (ins_en) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (edge_en) begin
					edges_q <= 1'b1;
				end
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			h_func_q <= skam_pkg::func_t'(req.func);
			h_key_q <= req.key;
			h_other_q <= req.other_key;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_key_q <= o_key_d;
			o_nb_q <= o_nb_d;
			o_st_q <= o_st_d;
			o_last_q <= o_last_d;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.row_key = o_key_q;
	assign rsp.neighbors = o_nb_q;
	assign rsp.status = o_st_q;
	assign rsp.is_last = o_last_q;

	`SKAM_CHECK(a_cnt_bound, clk, arst_n, CMPW'(cnt_q) <= CMPW'(NV), "key count above capacity")
	`SKAM_IMPLY(a_edges_nonempty, clk, arst_n, edges_q, cnt_q != '0, "edges on empty store")
	`SKAM_IMPLY(a_dump_idx, clk, arst_n, state_q == skam_pkg::S_DUMP, CMPW'(didx_q) < dump_n, "dump index past last row")

	generate
		for (i = 1; i < NV; i++) begin : g_order_chk
			`SKAM_CHECK(a_sorted, clk, arst_n, !(loaded[i] && (key_a[i] < key_a[i-1])), "stored keys out of order")
		end
	endgenerate

endmodule

FILE: test/sorted_key_adjacency_matrix_tb.sv
// testbench for the sorted key adjacency matrix: random and directed requests
`timescale 1ns / 1ps

module sorted_key_adjacency_matrix_tb;
	import skam_pkg::*;

	localparam int MAX_V = 16;

	typedef struct {
		key_t               row_key;
		logic [NB_W-1:0]    neighbors;
		status_t            status;
		logic               is_last;
	} graph_row_t;

	class graph_scoreboard;
		key_t            keys[MAX_V];
		logic [NB_W-1:0] rows[MAX_V];
		int              loaded;
		bit              edges_on;
		logic [VC_W-1:0] vertex_count;
		graph_row_t      pending[$];
		int              errors;

		function void reset_state();
			foreach (rows[i]) begin
				rows[i] = '0;
				keys[i] = '0;
			end
			loaded = 0;
			edges_on = 1'b0;
		endfunction

		function void push_row(key_t rk, logic [NB_W-1:0] nb, status_t st, logic last);
			graph_row_t r;
			r.row_key = rk;
			r.neighbors = nb;
			r.status = st;
			r.is_last = last;
			pending.push_back(r);
		endfunction

		function int find_key(key_t k);
			for (int i = 0; i < loaded && i < MAX_V; i++) begin
				if (keys[i] == k)
					return i;
			end
			return -1;
		endfunction

		function void note_request(func_t f, key_t k, key_t o);
			int cap;
			int pos;
			int a;
			int b;
			int n;
			cap = (vertex_count < MAX_V) ? int'(vertex_count) : MAX_V;
			case (f)
				FN_INSERT: begin
					if (edges_on || loaded >= cap) begin
						push_row('0, '0, ST_FULL, 1'b1);
					end else begin
						pos = loaded;
						while (pos > 0 && k < keys[pos-1]) begin
							keys[pos] = keys[pos-1];
							pos--;
						end
						keys[pos] = k;
						loaded++;
						push_row('0, '0, ST_OK, 1'b1);
					end
				end
				FN_EDGE: begin
					if (loaded == 0) begin
						push_row('0, '0, ST_EMPTY, 1'b1);
					end else begin
						a = find_key(k);
						b = find_key(o);
						if (a < 0 || b < 0) begin
							push_row('0, '0, ST_MISSING, 1'b1);
						end else begin
							rows[a][b] = 1'b1;
							edges_on = 1'b1;
							push_row('0, '0, ST_OK, 1'b1);
						end
					end
				end
				FN_DUMP: begin
					n = (loaded > RESULT_LIMIT) ? RESULT_LIMIT : loaded;
					if (n == 0)
						push_row('0, '0, ST_EMPTY, 1'b1);
					for (int i = 0; i < n; i++)
						push_row(keys[i], rows[i], ST_OK, (i + 1 == n));
				end
				default: begin
					reset_state();
					push_row('0, '0, ST_OK, 1'b1);
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(key_t rk, logic [NB_W-1:0] nb, logic [ST_W-1:0] st, logic last);
			graph_row_t e;
			if (pending.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				e = pending.pop_front();
				if (rk !== e.row_key)
					report_mismatch($sformatf("row_key %0d, want %0d", rk, e.row_key));
				if (nb !== e.neighbors)
					report_mismatch($sformatf("neighbors %h, want %h", nb, e.neighbors));
				if (st !== e.status)
					report_mismatch($sformatf("status %0d, want %0d", st, e.status));
				if (last !== e.is_last)
					report_mismatch($sformatf("is_last %b, want %b", last, e.is_last));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	skam_req_if req_ch();
	skam_rsp_if rsp_ch();

	sorted_key_adjacency_matrix DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	graph_scoreboard model;
	bit send_idle;
	bit recv_idle;
	int requests_sent;
	key_t used_keys[$];

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				model.note_request(func_t'(req_ch.func), req_ch.key, req_ch.other_key);
			if (rsp_ch.valid && rsp_ch.ready)
				model.check_result(rsp_ch.row_key, rsp_ch.neighbors, rsp_ch.status,
					rsp_ch.is_last);
		end
	end

	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			stall = recv_idle ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic send_request(func_t f, key_t k, key_t o);
		int gap;
		gap = send_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.key <= k;
		req_ch.other_key <= o;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
		if (f == FN_INSERT)
			used_keys.push_back(k);
		if (f == FN_CLEAR)
			used_keys.delete();
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		// let the monitor note the last accepted request first
		@(posedge clk);
		while (model.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vertex_count(logic [VC_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * REG_VERTEX_COUNT);
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model.vertex_count = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic key_t random_key();
		int r;
		r = $urandom_range(0, 3);
		case (r)
			0: return key_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return key_t'($urandom_range(0, 16)) - 8;
		endcase
	endfunction

	function automatic key_t pick_key();
		if (used_keys.size() > 0 && $urandom_range(0, 9) < 8)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		return random_key();
	endfunction

	task automatic graph_phase();
		int n_ins;
		int n_ops;
		int r;
		if ($urandom_range(0, 1))
			send_request(FN_CLEAR, random_key(), random_key());
		n_ins = $urandom_range(0, 18);
		repeat (n_ins) send_request(FN_INSERT, random_key(), random_key());
		if ($urandom_range(0, 1))
			send_request(FN_DUMP, random_key(), random_key());
		n_ops = $urandom_range(10, 30);
		repeat (n_ops) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send_request(FN_EDGE, pick_key(), pick_key());
			else if (r < 70)
				send_request(FN_DUMP, random_key(), random_key());
			else if (r < 80)
				send_request(FN_INSERT, random_key(), random_key());
			else if (r < 84)
				send_request(FN_CLEAR, random_key(), random_key());
			else
				send_request(func_t'($urandom_range(0, 3)), random_key(), random_key());
		end
		send_request(FN_DUMP, random_key(), random_key());
	endtask

	initial begin
		logic [VC_W-1:0] vc;
		model = new();
		model.reset_state();
		model.vertex_count = VC_RESET;
		clk = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FN_INSERT;
		req_ch.key <= '0;
		req_ch.other_key <= '0;
		rsp_ch.ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store cases, then inserts of extreme and repeated keys
		send_request(FN_DUMP, '0, '0);
		send_request(FN_EDGE, '0, '0);
		send_request(FN_INSERT, 32'sh7fffffff, '0);
		send_request(FN_INSERT, 32'sh80000000, '0);
		send_request(FN_INSERT, '0, '0);
		send_request(FN_INSERT, '1, '0);
		send_request(FN_INSERT, 32'sd5, '0);
		send_request(FN_INSERT, 32'sd5, '0);
		send_request(FN_INSERT, 32'sd1, '0);
		drain_results();
		// capacity lowered below the loaded count, then edge requests
		write_vertex_count(5'd4);
		send_request(FN_INSERT, 32'sd2, '0);
		send_request(FN_EDGE, 32'sd7, 32'sd5);
		send_request(FN_EDGE, 32'sd5, 32'sd5);
		send_request(FN_EDGE, 32'sh7fffffff, 32'sh80000000);
		send_request(FN_EDGE, 32'sh80000000, 32'sh7fffffff);
		send_request(FN_EDGE, '1, '0);
		drain_results();
		write_vertex_count(5'd31);
		send_request(FN_INSERT, 32'sd3, '0);
		send_request(FN_DUMP, '0, '0);
		send_request(FN_CLEAR, '0, '0);
		drain_results();
		write_vertex_count(5'd0);
		send_request(FN_INSERT, 32'sd3, '0);
		drain_results();
		write_vertex_count(5'd1);
		send_request(FN_INSERT, 32'sd3, '0);
		send_request(FN_INSERT, 32'sd4, '0);
		send_request(FN_DUMP, '0, '0);
		drain_results();
		write_vertex_count(5'd16);

		while (requests_sent < 410) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			graph_phase();
			drain_results();
			case ($urandom_range(0, 9))
				0: vc = 5'd0;
				1: vc = 5'd1;
				2: vc = 5'd31;
				3: vc = 5'd16;
				4: vc = 5'd2;
				default: vc = VC_W'($urandom_range(1, 16));
			endcase
			write_vertex_count(vc);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (model.pending.size() != 0)
			model.report_mismatch("results still pending at end");
		if (model.errors == 0)
			$display("sorted_key_adjacency_matrix_tb OK");
		else
			$display("sorted_key_adjacency_matrix_tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("sorted_key_adjacency_matrix_tb NOT OK");
		$finish;
	end

endmodule
